[sv/dvl_pkg.sv]
// shared types, widths and constants for the diffuse vertex lighting unit
package dvl_pkg;

   localparam int COORD_WIDTH     = 16;
   localparam int COORD_FRAC_BITS = 8;
   localparam int NORM_WIDTH      = 16;
   localparam int COLOR_WIDTH     = 16;
   localparam int LIT_WIDTH       = 14;
   localparam int CSR_WIDTH       = 48;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam int ONE_Q13 = 8192;
   localparam int Q14_BITS = 14;

   // light minus vertex, and its magnitude after range reduction
   localparam int DW           = COORD_WIDTH + 1;
   localparam int D_LIMIT_BITS = 24;
   localparam int MAGW         = (DW > D_LIMIT_BITS) ? D_LIMIT_BITS : DW;
   localparam int SHW          = 6;

   // squared length and its radicand
   localparam int SQW   = 2 * MAGW;
   localparam int LW    = SQW + 2;
   localparam int XW    = LW + 12;
   localparam int RADW  = XW + (XW % 2);
   localparam int ROOTW = RADW / 2;
   localparam int REMW  = ROOTW + 2;

   // numerator and quotient
   localparam int PRODW  = MAGW + 1 + NORM_WIDTH;
   localparam int NUMW   = PRODW + 2;
   localparam int DIVIDW = NUMW + 6;
   localparam int QB     = 17;
   localparam int DREMW  = ROOTW + 1;
   localparam int CPHIW  = QB + 1;

   // color accumulation
   localparam int PW   = CPHIW + COLOR_WIDTH;
   localparam int ACCW = PW + 2;

   localparam int REQ_W = ((3 * COORD_WIDTH + 3 * NORM_WIDTH + 7) / 8) * 8;
   localparam int RSP_W = 64;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_LIGHT_X    = 3'd0,
      REG_LIGHT_Y    = 3'd1,
      REG_LIGHT_Z    = 3'd2,
      REG_LIGHT_W    = 3'd3,
      REG_BASE_RGB   = 3'd4,
      REG_BASE_ALPHA = 3'd5,
      REG_GAIN_RGB   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x;
      logic signed [COORD_WIDTH-1:0] y;
      logic signed [COORD_WIDTH-1:0] z;
      logic signed [COORD_WIDTH-1:0] w;
   } light_type;

   typedef struct packed {
      logic [3*COLOR_WIDTH-1:0] base_rgb;
      logic [COLOR_WIDTH-1:0]   base_alpha;
      logic [3*COLOR_WIDTH-1:0] gain_rgb;
   } color_cfg_type;

   typedef struct packed {
      logic [RADW-1:0]  rad;
      logic [ROOTW-1:0] root;
      logic [REMW-1:0]  rem;
      logic [NUMW-1:0]  num_mag;
      logic             num_neg;
      logic             degen;
   } sqrt_pipe_type;

   typedef struct packed {
      logic [DREMW-1:0] rem;
      logic [QB-1:0]    dq;
      logic [ROOTW-1:0] divisor;
      logic             num_neg;
      logic             degen;
   } div_pipe_type;

   typedef struct packed {
      logic             degenerate;
      logic [COLOR_WIDTH-1:0] lit_alpha;
      logic [LIT_WIDTH-1:0]   lit_blue;
      logic [LIT_WIDTH-1:0]   lit_green;
      logic [LIT_WIDTH-1:0]   lit_red;
   } lit_type;

endpackage

[sv/diffuse_vertex_lighting_unit.sv]
// top level of the diffuse vertex lighting unit
// Takes one vertex transaction per clock unless stalled and returns one lit color per
// vertex, in order. It has three front stages for the light vector, squares and dot
// products, one square root cell per root bit (ROOTW = 24), one divider cell per quotient
// bit (17) and two color stages ending in the output register. Every stage holds its own
// transaction and moves on when the next one is free, so the unit keeps taking vertices
// while results wait, as long as a stage has room. Write the light, color and gain
// registers via the csr port only while no vertex is in flight; the unit does not check.
module diffuse_vertex_lighting_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // vertex_x, vertex_y, vertex_z, normal_x, normal_y, normal_z
   input  logic [dvl_pkg::REQ_W-1:0]           req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // lit_red, lit_green, lit_blue, lit_alpha, degenerate, zero fill
   output logic [dvl_pkg::RSP_W-1:0]           rsp_tdata,
   input  logic                                csr_wr_en,
   input  logic [dvl_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [dvl_pkg::CSR_WIDTH-1:0]       csr_wr_data
);

   localparam int CW = dvl_pkg::COORD_WIDTH;
   localparam int NW = dvl_pkg::NORM_WIDTH;

   dvl_pkg::light_type     light_ff;
   dvl_pkg::color_cfg_type color_ff;

   logic                   sqrt_valid [dvl_pkg::ROOTW+1];
   logic                   sqrt_ready [dvl_pkg::ROOTW+1];
   dvl_pkg::sqrt_pipe_type sqrt_data  [dvl_pkg::ROOTW+1];
   logic                   div_valid  [dvl_pkg::QB+1];
   logic                   div_ready  [dvl_pkg::QB+1];
   dvl_pkg::div_pipe_type  div_data   [dvl_pkg::QB+1];
   dvl_pkg::lit_type       lit;

   always_ff @(posedge clock) begin
      if (reset) begin
         light_ff.x          <= '0;
         light_ff.y          <= '0;
         light_ff.z          <= '0;
         light_ff.w          <= CW'(1 << dvl_pkg::COORD_FRAC_BITS);
         color_ff.base_rgb   <= '0;
         color_ff.base_alpha <= dvl_pkg::COLOR_WIDTH'(dvl_pkg::ONE_Q13);
         color_ff.gain_rgb   <= '0;
      end else if (csr_wr_en) begin
         case (dvl_pkg::csr_index_type'(csr_index))
            dvl_pkg::REG_LIGHT_X:    light_ff.x          <= csr_wr_data[CW-1:0];
            dvl_pkg::REG_LIGHT_Y:    light_ff.y          <= csr_wr_data[CW-1:0];
            dvl_pkg::REG_LIGHT_Z:    light_ff.z          <= csr_wr_data[CW-1:0];
            dvl_pkg::REG_LIGHT_W:    light_ff.w          <= csr_wr_data[CW-1:0];
            dvl_pkg::REG_BASE_RGB:   color_ff.base_rgb   <= csr_wr_data;
            dvl_pkg::REG_BASE_ALPHA: color_ff.base_alpha <= csr_wr_data[15:0];
            dvl_pkg::REG_GAIN_RGB:   color_ff.gain_rgb   <= csr_wr_data;
            default: ;
         endcase
      end
   end

   dvl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .light     (light_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .vertex_x  (req_tdata[CW-1:0]),
      .vertex_y  (req_tdata[2*CW-1:CW]),
      .vertex_z  (req_tdata[3*CW-1:2*CW]),
      .normal_x  (req_tdata[3*CW+NW-1:3*CW]),
      .normal_y  (req_tdata[3*CW+2*NW-1:3*CW+NW]),
      .normal_z  (req_tdata[3*CW+3*NW-1:3*CW+2*NW]),
      .out_valid (sqrt_valid[0]),
      .out_ready (sqrt_ready[0]),
      .out_data  (sqrt_data[0])
   );

   for (genvar k = 0; k < dvl_pkg::ROOTW; k++) begin : g_sqrt
      dvl_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sqrt_valid[k]),
         .in_ready  (sqrt_ready[k]),
         .in_data   (sqrt_data[k]),
         .out_valid (sqrt_valid[k+1]),
         .out_ready (sqrt_ready[k+1]),
         .out_data  (sqrt_data[k+1])
      );
   end

   // seed the divider with numerator * 64 over the root
   always_comb begin
      logic [dvl_pkg::DIVIDW-1:0] dividend;
      logic [dvl_pkg::DIVIDW-1:0] hi;
      dividend             = {sqrt_data[dvl_pkg::ROOTW].num_mag, 6'b0};
      hi                   = dividend >> dvl_pkg::QB;
      div_data[0].rem      = {1'b0, hi[dvl_pkg::ROOTW-1:0]};
      div_data[0].dq       = dividend[dvl_pkg::QB-1:0];
      div_data[0].divisor  = sqrt_data[dvl_pkg::ROOTW].root;
      div_data[0].num_neg  = sqrt_data[dvl_pkg::ROOTW].num_neg;
      div_data[0].degen    = sqrt_data[dvl_pkg::ROOTW].degen;
   end
   assign div_valid[0]               = sqrt_valid[dvl_pkg::ROOTW];
   assign sqrt_ready[dvl_pkg::ROOTW] = div_ready[0];

   for (genvar k = 0; k < dvl_pkg::QB; k++) begin : g_div
      dvl_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[k]),
         .in_ready  (div_ready[k]),
         .in_data   (div_data[k]),
         .out_valid (div_valid[k+1]),
         .out_ready (div_ready[k+1]),
         .out_data  (div_data[k+1])
      );
   end

   dvl_color u_color (
      .clock     (clock),
      .reset     (reset),
      .cfg       (color_ff),
      .in_valid  (div_valid[dvl_pkg::QB]),
      .in_ready  (div_ready[dvl_pkg::QB]),
      .in_data   (div_data[dvl_pkg::QB]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (lit)
   );

   assign rsp_tdata = dvl_pkg::RSP_W'(lit);

endmodule

[sv/dvl_front.sv]
// front stages: light minus vertex vector, range reduction, products and sums
module dvl_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  dvl_pkg::light_type                    light,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic signed [dvl_pkg::COORD_WIDTH-1:0] vertex_x,
   input  logic signed [dvl_pkg::COORD_WIDTH-1:0] vertex_y,
   input  logic signed [dvl_pkg::COORD_WIDTH-1:0] vertex_z,
   input  logic signed [dvl_pkg::NORM_WIDTH-1:0]  normal_x,
   input  logic signed [dvl_pkg::NORM_WIDTH-1:0]  normal_y,
   input  logic signed [dvl_pkg::NORM_WIDTH-1:0]  normal_z,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output dvl_pkg::sqrt_pipe_type                out_data
);

   logic a_valid_ff, b_valid_ff, c_valid_ff;
   logic a_ready, b_ready, c_ready;

   logic signed [dvl_pkg::DW-1:0]         d_ff [4];
   logic signed [dvl_pkg::DW-1:0]         d_in [4];
   logic signed [dvl_pkg::NORM_WIDTH-1:0] n_ff [3];
   logic [dvl_pkg::SQW-1:0]               sq_ff [4];
   logic [dvl_pkg::SQW-1:0]               sq_in [4];
   logic signed [dvl_pkg::PRODW-1:0]      pr_ff [4];
   logic signed [dvl_pkg::PRODW-1:0]      pr_in [4];
   dvl_pkg::sqrt_pipe_type                out_ff;
   dvl_pkg::sqrt_pipe_type                out_in;

   assign c_ready  = !c_valid_ff || out_ready;
   assign b_ready  = !b_valid_ff || c_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   // stage a: light minus vertex, w against 1.0
   always_comb begin
      d_in[0] = dvl_pkg::DW'(light.x) - dvl_pkg::DW'(vertex_x);
      d_in[1] = dvl_pkg::DW'(light.y) - dvl_pkg::DW'(vertex_y);
      d_in[2] = dvl_pkg::DW'(light.z) - dvl_pkg::DW'(vertex_z);
      d_in[3] = dvl_pkg::DW'(light.w) - dvl_pkg::DW'(1 << dvl_pkg::COORD_FRAC_BITS);
   end

   // stage b: shift magnitudes below the limit, squares and dot products
   always_comb begin
      logic [dvl_pkg::DW-1:0]          mag [4];
      logic [dvl_pkg::DW-1:0]          orv;
      logic [dvl_pkg::SHW-1:0]         s;
      logic [dvl_pkg::DW-1:0]          shifted;
      logic [dvl_pkg::MAGW-1:0]        mag_s [4];
      logic signed [dvl_pkg::MAGW:0]   ds [4];
      orv = '0;
      s   = '0;
      for (int i = 0; i < 4; i++) begin
         mag[i] = d_ff[i][dvl_pkg::DW-1] ? dvl_pkg::DW'(-d_ff[i]) : dvl_pkg::DW'(d_ff[i]);
         orv    = orv | mag[i];
      end
      for (int k = dvl_pkg::D_LIMIT_BITS; k < dvl_pkg::DW; k++) begin
         if (orv[k]) begin
            s = dvl_pkg::SHW'(k - dvl_pkg::D_LIMIT_BITS + 1);
         end
      end
      for (int i = 0; i < 4; i++) begin
         shifted  = mag[i] >> s;
         mag_s[i] = shifted[dvl_pkg::MAGW-1:0];
         ds[i]    = d_ff[i][dvl_pkg::DW-1] ? -$signed({1'b0, mag_s[i]})
                                           : $signed({1'b0, mag_s[i]});
         sq_in[i] = dvl_pkg::SQW'(mag_s[i]) * dvl_pkg::SQW'(mag_s[i]);
      end
      for (int i = 0; i < 3; i++) begin
         pr_in[i] = dvl_pkg::PRODW'(ds[i]) * dvl_pkg::PRODW'(n_ff[i]);
      end
      pr_in[3] = dvl_pkg::PRODW'(ds[3]) <<< dvl_pkg::Q14_BITS;
   end

   // stage c: length squared and numerator, seed the root cells
   always_comb begin
      logic [dvl_pkg::LW-1:0]          len2;
      logic signed [dvl_pkg::NUMW-1:0] num;
      len2 = '0;
      num  = '0;
      for (int i = 0; i < 4; i++) begin
         len2 = len2 + dvl_pkg::LW'(sq_ff[i]);
         num  = num + dvl_pkg::NUMW'(pr_ff[i]);
      end
      out_in.rad     = dvl_pkg::RADW'({len2, 12'b0});
      out_in.root    = '0;
      out_in.rem     = '0;
      out_in.num_neg = num[dvl_pkg::NUMW-1];
      out_in.num_mag = num[dvl_pkg::NUMW-1] ? dvl_pkg::NUMW'(-num) : dvl_pkg::NUMW'(num);
      out_in.degen   = (len2 == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (a_ready) begin
            a_valid_ff <= in_valid;
         end
         if (b_ready) begin
            b_valid_ff <= a_valid_ff;
         end
         if (c_ready) begin
            c_valid_ff <= b_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && in_valid) begin
         d_ff    <= d_in;
         n_ff[0] <= normal_x;
         n_ff[1] <= normal_y;
         n_ff[2] <= normal_z;
      end
      if (b_ready && a_valid_ff) begin
         sq_ff <= sq_in;
         pr_ff <= pr_in;
      end
      if (c_ready && b_valid_ff) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = c_valid_ff;
   assign out_data  = out_ff;

endmodule

[sv/dvl_sqrt_cell.sv]
// one cell of the square root chain: one root bit per cell
module dvl_sqrt_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  dvl_pkg::sqrt_pipe_type in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output dvl_pkg::sqrt_pipe_type out_data
);

   logic                   valid_ff;
   dvl_pkg::sqrt_pipe_type data_ff;
   dvl_pkg::sqrt_pipe_type data_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      logic [dvl_pkg::REMW-1:0] rem2;
      logic [dvl_pkg::REMW-1:0] trial;
      rem2    = {in_data.rem[dvl_pkg::REMW-3:0], in_data.rad[dvl_pkg::RADW-1 -: 2]};
      trial   = {in_data.root, 2'b01};
      data_in = in_data;
      data_in.rad = in_data.rad << 2;
      if (rem2 >= trial) begin
         data_in.rem  = rem2 - trial;
         data_in.root = {in_data.root[dvl_pkg::ROOTW-2:0], 1'b1};
      end else begin
         data_in.rem  = rem2;
         data_in.root = {in_data.root[dvl_pkg::ROOTW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

`ifndef SYNTHESIS
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (dvl_pkg::REMW'(data_ff.rem) <= dvl_pkg::REMW'({data_ff.root, 1'b0})))
      else $error("root remainder above twice the partial root");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !out_ready |=> valid_ff && $stable(data_ff))
      else $error("root cell lost its transaction while stalled");
`endif

endmodule

[sv/dvl_div_cell.sv]
// one cell of the divider chain: one quotient bit per cell
module dvl_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  dvl_pkg::div_pipe_type in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output dvl_pkg::div_pipe_type out_data
);

   logic                  valid_ff;
   dvl_pkg::div_pipe_type data_ff;
   dvl_pkg::div_pipe_type data_in;

   assign in_ready = !valid_ff || out_ready;

   // dq holds the dividend bits still to come on top and the quotient below
   always_comb begin
      logic [dvl_pkg::DREMW-1:0] rem2;
      logic [dvl_pkg::DREMW-1:0] dvs;
      rem2    = {in_data.rem[dvl_pkg::DREMW-2:0], in_data.dq[dvl_pkg::QB-1]};
      dvs     = {1'b0, in_data.divisor};
      data_in = in_data;
      if (rem2 >= dvs) begin
         data_in.rem = rem2 - dvs;
         data_in.dq  = {in_data.dq[dvl_pkg::QB-2:0], 1'b1};
      end else begin
         data_in.rem = rem2;
         data_in.dq  = {in_data.dq[dvl_pkg::QB-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

`ifndef SYNTHESIS
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !data_ff.degen |-> (data_ff.rem < {1'b0, data_ff.divisor}))
      else $error("divider remainder not below divisor");
`endif

endmodule

[sv/dvl_color.sv]
// color stages: cosine times gain, add base, clamp, output register
module dvl_color (
   input  logic                   clock,
   input  logic                   reset,
   input  dvl_pkg::color_cfg_type cfg,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  dvl_pkg::div_pipe_type  in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output dvl_pkg::lit_type       out_data
);

   logic m_valid_ff, o_valid_ff;
   logic m_ready, o_ready;
   logic signed [dvl_pkg::PW-1:0] prod_ff [3];
   logic signed [dvl_pkg::PW-1:0] prod_in [3];
   logic                          degen_ff;
   dvl_pkg::lit_type              out_ff;
   dvl_pkg::lit_type              out_in;

   assign o_ready  = !o_valid_ff || out_ready;
   assign m_ready  = !m_valid_ff || o_ready;
   assign in_ready = m_ready;

   always_comb begin
      logic signed [dvl_pkg::CPHIW-1:0] cphi;
      logic signed [dvl_pkg::CPHIW-1:0] q;
      q = $signed(dvl_pkg::CPHIW'(in_data.dq));
      if (in_data.degen) begin
         cphi = '0;
      end else if (in_data.num_neg) begin
         cphi = -q;
      end else begin
         cphi = q;
      end
      for (int c = 0; c < 3; c++) begin
         prod_in[c] = dvl_pkg::PW'(cphi) *
                      dvl_pkg::PW'($signed(cfg.gain_rgb[dvl_pkg::COLOR_WIDTH*c +: 
                                                        dvl_pkg::COLOR_WIDTH]));
      end
   end

   always_comb begin
      logic signed [dvl_pkg::ACCW-1:0]  acc;
      logic [dvl_pkg::ACCW-15:0]        v;
      logic [dvl_pkg::LIT_WIDTH-1:0]    lit [3];
      for (int c = 0; c < 3; c++) begin
         acc = (dvl_pkg::ACCW'($signed(cfg.base_rgb[dvl_pkg::COLOR_WIDTH*c +:
                                                    dvl_pkg::COLOR_WIDTH]))
                <<< dvl_pkg::Q14_BITS) + dvl_pkg::ACCW'(prod_ff[c]);
         v = acc[dvl_pkg::ACCW-1:dvl_pkg::Q14_BITS];
         if (acc <= 0) begin
            lit[c] = '0;
         end else if (v > (dvl_pkg::ACCW-14)'(dvl_pkg::ONE_Q13)) begin
            lit[c] = dvl_pkg::LIT_WIDTH'(dvl_pkg::ONE_Q13);
         end else begin
            lit[c] = v[dvl_pkg::LIT_WIDTH-1:0];
         end
      end
      out_in.lit_red    = lit[0];
      out_in.lit_green  = lit[1];
      out_in.lit_blue   = lit[2];
      out_in.lit_alpha  = cfg.base_alpha;
      out_in.degenerate = degen_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (m_ready) begin
            m_valid_ff <= in_valid;
         end
         if (o_ready) begin
            o_valid_ff <= m_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (m_ready && in_valid) begin
         prod_ff  <= prod_in;
         degen_ff <= in_data.degen;
      end
      if (o_ready && m_valid_ff) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = o_valid_ff;
   assign out_data  = out_ff;

endmodule
